// File: rtl/core/lz4bd_pkg.sv
// lz4bd_pkg: shared types and constants of the lz4 block decoder
`timescale 1ns / 1ps
`default_nettype none
package lz4bd_pkg;

   localparam int WINDOW_BYTES = 65536;
   localparam int HIST_ADDR_W  = $clog2(WINDOW_BYTES);
   localparam int RAW_SIZE_W   = 24;
   localparam int COUNT_W      = 32;

   localparam logic [3:0] NIBBLE_EXT = 4'hF;
   localparam logic [7:0] BYTE_EXT   = 8'hFF;
   localparam int         MIN_MATCH  = 4;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_TRUNC = 2'd1,
      ST_DIST  = 2'd2,
      ST_SIZE  = 2'd3
   } status_type;

   typedef enum logic [7:0] {
      PH_TOKEN   = 8'b0000_0001,
      PH_LITLEN  = 8'b0000_0010,
      PH_LITERAL = 8'b0000_0100,
      PH_OFFLO   = 8'b0000_1000,
      PH_OFFHI   = 8'b0001_0000,
      PH_MATLEN  = 8'b0010_0000,
      PH_COPY    = 8'b0100_0000,
      PH_SKIP    = 8'b1000_0000
   } phase_type;

   // transaction in flight between parse and output register
   typedef struct packed {
      logic                   from_ram;
      logic [7:0]             lit_byte;
      logic                   out_valid;
      logic                   match_pending;
      logic                   frame_done;
      status_type             status;
      logic [HIST_ADDR_W-1:0] rd_addr;
      logic [HIST_ADDR_W-1:0] wr_addr;
   } work_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       match_pending;
      logic       frame_done;
      status_type status;
   } result_type;

endpackage
`default_nettype wire

// File: rtl/core/lz4bd_req_if.sv
// lz4bd_req_if: request channel carrying compressed bytes and drain commands
`timescale 1ns / 1ps
`default_nettype none
interface lz4bd_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output cmd, output in_byte, output in_last, input ready);
   modport sink   (input valid, input cmd, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lz4bd_rsp_if.sv
// lz4bd_rsp_if: response channel carrying decoded bytes and block status
`timescale 1ns / 1ps
`default_nettype none
interface lz4bd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       match_pending;
   logic       frame_done;
   logic [1:0] status;

   modport source (output valid, output out_byte, output out_valid, output match_pending,
                   output frame_done, output status, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input match_pending,
                   input frame_done, input status, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lz4bd_ram.sv
// lz4bd_ram: generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module lz4bd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read returns old data on a same-address write
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: rtl/core/lz4_block_decoder.sv
// lz4_block_decoder: streaming lz4 block decoder, one byte or drain per transaction
// an accepted transaction passes the stage-1 and stage-2 registers before its result leaves
// one transaction per cycle unless rsp_chan stalls, set by the single ram read per drain
// history ram read is registered; the byte written just before is forwarded
// reset clears parse state, counters, raw_size and pipeline valids
// history contents are undefined after reset and get no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module lz4_block_decoder import lz4bd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lz4bd_req_if.sink                  req_chan,
   lz4bd_rsp_if.source                rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [RAW_SIZE_W-1:0] csr_wr_data
);
   logic [RAW_SIZE_W-1:0]  raw_size_ff;
   phase_type              phase_ff, phase_in;
   logic [3:0]             tmn_ff, tmn_in;
   logic [COUNT_W-1:0]     lit_left_ff, lit_left_in;
   logic [HIST_ADDR_W-1:0] dist_ff, dist_in;
   logic [COUNT_W-1:0]     match_left_ff, match_left_in;
   logic [COUNT_W-1:0]     dcount_ff, dcount_in;
   logic [HIST_ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic                   input_ended_ff, input_ended_in;

   work_type               s1_ff, s1_in;
   logic                   s1_valid_ff;
   result_type             s2_ff, s2_in;
   logic                   s2_valid_ff;

   logic                   prev_valid_ff;
   logic [HIST_ADDR_W-1:0] prev_addr_ff;
   logic [7:0]             prev_data_ff;

   logic                   s2_load, s1_move, accept;
   logic [7:0]             ram_rd_data, byte_val;
   logic                   fwd_hit;

   logic [COUNT_W-1:0]     raw_ext;
   logic [COUNT_W:0]       lit_sum, ml_sum;
   logic [COUNT_W+1:0]     ml_plus;
   logic                   end_req, end_last;
   status_type             end_st;
   logic [7:0]             b;
   logic                   last;

   assign s2_load        = !s2_valid_ff || rsp_chan.ready;
   assign s1_move        = s1_valid_ff && s2_load;
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign accept         = req_chan.valid && req_chan.ready;

   assign raw_ext = {{(COUNT_W-RAW_SIZE_W){1'b0}}, raw_size_ff};
   assign b       = req_chan.in_byte;
   assign last    = req_chan.in_last;
   assign lit_sum = {1'b0, lit_left_ff} + {{(COUNT_W-7){1'b0}}, b};
   assign ml_sum  = {1'b0, match_left_ff} + {{(COUNT_W-7){1'b0}}, b};
   assign ml_plus = {2'b00, match_left_ff} + {{(COUNT_W-6){1'b0}}, b}
                    + (COUNT_W+2)'(MIN_MATCH);

   // parse step: next state and the transaction handed to stage 1
   always_comb begin
      phase_in       = phase_ff;
      tmn_in         = tmn_ff;
      lit_left_in    = lit_left_ff;
      dist_in        = dist_ff;
      match_left_in  = match_left_ff;
      dcount_in      = dcount_ff;
      wr_ptr_in      = wr_ptr_ff;
      input_ended_in = input_ended_ff;
      end_req        = 1'b0;
      end_last       = 1'b0;
      end_st         = ST_OK;
      s1_in          = '0;
      s1_in.status   = ST_OK;
      s1_in.rd_addr  = wr_ptr_ff - dist_ff;
      s1_in.wr_addr  = wr_ptr_ff;

      if (req_chan.cmd) begin
         if (phase_ff == PH_COPY) begin
            s1_in.from_ram  = 1'b1;
            s1_in.out_valid = 1'b1;
            wr_ptr_in       = wr_ptr_ff + HIST_ADDR_W'(1);
            dcount_in       = (&dcount_ff) ? dcount_ff : dcount_ff + COUNT_W'(1);
            match_left_in   = match_left_ff - COUNT_W'(1);
            if (match_left_in == '0) begin
               if (dcount_in >= raw_ext) begin
                  end_req  = 1'b1;
                  end_last = input_ended_ff;
                  end_st   = (dcount_in == raw_ext) ? ST_OK : ST_SIZE;
               end else if (input_ended_ff) begin
                  end_req  = 1'b1;
                  end_last = 1'b1;
                  end_st   = ST_SIZE;
               end else begin
                  phase_in = PH_TOKEN;
               end
            end
         end
      end else if (phase_ff == PH_SKIP) begin
         if (last) begin
            phase_in  = PH_TOKEN;
            dcount_in = '0;
         end
      end else if (phase_ff != PH_COPY) begin
         unique case (phase_ff)
            PH_TOKEN: begin
               if (dcount_ff >= raw_ext) begin
                  end_req  = 1'b1;
                  end_last = last;
                  end_st   = (dcount_ff == raw_ext) ? ST_OK : ST_SIZE;
               end else begin
                  tmn_in      = b[3:0];
                  lit_left_in = {{(COUNT_W-4){1'b0}}, b[7:4]};
                  if (b[7:4] == NIBBLE_EXT) begin
                     phase_in = PH_LITLEN;
                  end else if (b[7:4] != 4'd0) begin
                     phase_in = PH_LITERAL;
                  end else begin
                     phase_in = PH_OFFLO;
                  end
               end
            end
            PH_LITLEN: begin
               lit_left_in = lit_sum[COUNT_W] ? '1 : lit_sum[COUNT_W-1:0];
               if (b != BYTE_EXT) begin
                  phase_in = PH_LITERAL;
               end
            end
            PH_LITERAL: begin
               s1_in.lit_byte  = b;
               s1_in.out_valid = 1'b1;
               wr_ptr_in       = wr_ptr_ff + HIST_ADDR_W'(1);
               dcount_in       = (&dcount_ff) ? dcount_ff : dcount_ff + COUNT_W'(1);
               lit_left_in     = lit_left_ff - COUNT_W'(1);
               if (lit_left_in == '0) begin
                  if (dcount_in >= raw_ext) begin
                     end_req  = 1'b1;
                     end_last = last;
                     end_st   = (dcount_in == raw_ext) ? ST_OK : ST_SIZE;
                  end else begin
                     phase_in = PH_OFFLO;
                  end
               end
            end
            PH_OFFLO: begin
               dist_in  = {8'd0, b};
               phase_in = PH_OFFHI;
            end
            PH_OFFHI: begin
               dist_in = {b, dist_ff[7:0]};
               if (tmn_ff == NIBBLE_EXT) begin
                  match_left_in = {{(COUNT_W-4){1'b0}}, tmn_ff};
                  phase_in      = PH_MATLEN;
               end else begin
                  match_left_in = {{(COUNT_W-4){1'b0}}, tmn_ff} + COUNT_W'(MIN_MATCH);
                  if (dist_in == '0 || {{(COUNT_W-HIST_ADDR_W){1'b0}}, dist_in} > dcount_ff)
                  begin
                     end_req  = 1'b1;
                     end_last = last;
                     end_st   = ST_DIST;
                  end else begin
                     phase_in = PH_COPY;
                  end
               end
            end
            PH_MATLEN: begin
               if (b == BYTE_EXT) begin
                  match_left_in = ml_sum[COUNT_W] ? '1 : ml_sum[COUNT_W-1:0];
               end else begin
                  match_left_in = (ml_plus[COUNT_W+1:COUNT_W] != 2'b00) ? '1
                                  : ml_plus[COUNT_W-1:0];
                  if (dist_ff == '0 || {{(COUNT_W-HIST_ADDR_W){1'b0}}, dist_ff} > dcount_ff)
                  begin
                     end_req  = 1'b1;
                     end_last = last;
                     end_st   = ST_DIST;
                  end else begin
                     phase_in = PH_COPY;
                  end
               end
            end
            default: begin
            end
         endcase
         // in_last on a byte that did not already end the block
         if (!end_req && last) begin
            if (phase_in == PH_COPY) begin
               input_ended_in = 1'b1;
            end else if (phase_in == PH_TOKEN) begin
               end_req  = 1'b1;
               end_last = 1'b1;
               end_st   = ST_SIZE;
            end else begin
               end_req  = 1'b1;
               end_last = 1'b1;
               end_st   = ST_TRUNC;
            end
         end
      end

      if (end_req) begin
         s1_in.frame_done = 1'b1;
         s1_in.status     = end_st;
         input_ended_in   = 1'b0;
         if (end_last) begin
            phase_in  = PH_TOKEN;
            dcount_in = '0;
         end else begin
            phase_in = PH_SKIP;
         end
      end
      s1_in.match_pending = (phase_in == PH_COPY);
   end

   lz4bd_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_BYTES)
   ) u_history (
      .clock   (clock),
      .wr_en   (s1_move && s1_ff.out_valid),
      .wr_addr (s1_ff.wr_addr),
      .wr_data (byte_val),
      .rd_en   (accept),
      .rd_addr (s1_in.rd_addr),
      .rd_data (ram_rd_data)
   );

   // the last byte written may not be in the ram yet when this read was issued
   assign fwd_hit  = prev_valid_ff && (prev_addr_ff == s1_ff.rd_addr);
   assign byte_val = s1_ff.from_ram ? (fwd_hit ? prev_data_ff : ram_rd_data) : s1_ff.lit_byte;

   always_comb begin
      s2_in.out_byte      = byte_val;
      s2_in.out_valid     = s1_ff.out_valid;
      s2_in.match_pending = s1_ff.match_pending;
      s2_in.frame_done    = s1_ff.frame_done;
      s2_in.status        = s1_ff.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_size_ff    <= '0;
         phase_ff       <= PH_TOKEN;
         tmn_ff         <= '0;
         lit_left_ff    <= '0;
         dist_ff        <= '0;
         match_left_ff  <= '0;
         dcount_ff      <= '0;
         wr_ptr_ff      <= '0;
         input_ended_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         prev_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            raw_size_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff       <= phase_in;
            tmn_ff         <= tmn_in;
            lit_left_ff    <= lit_left_in;
            dist_ff        <= dist_in;
            match_left_ff  <= match_left_in;
            dcount_ff      <= dcount_in;
            wr_ptr_ff      <= wr_ptr_in;
            input_ended_ff <= input_ended_in;
         end
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s1_move && s1_ff.out_valid) begin
            prev_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         s2_ff <= s2_in;
      end
      if (s1_move && s1_ff.out_valid) begin
         prev_addr_ff <= s1_ff.wr_addr;
         prev_data_ff <= byte_val;
      end
   end

   assign rsp_chan.valid         = s2_valid_ff;
   assign rsp_chan.out_byte      = s2_ff.out_byte;
   assign rsp_chan.out_valid     = s2_ff.out_valid;
   assign rsp_chan.match_pending = s2_ff.match_pending;
   assign rsp_chan.frame_done    = s2_ff.frame_done;
   assign rsp_chan.status        = s2_ff.status;

   // a stalled stage-1 transaction must not change or it would be written twice differently
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_ff))
      else $error("stage 1 changed while stalled");

   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_ff.status != ST_OK |-> s2_ff.frame_done)
      else $error("error status without block end");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_ff.out_valid |-> s2_ff.out_byte == 8'd0)
      else $error("out_byte nonzero without a decoded byte");

   a_copy_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_COPY |-> match_left_ff != '0)
      else $error("copy phase with no match bytes left");

   a_drain_from_ram: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.from_ram |-> s1_ff.out_valid && s1_ff.lit_byte == 8'd0)
      else $error("ram-sourced transaction without a decoded byte");
endmodule
`default_nettype wire
